@@ rtl/core/ece_pkg.sv @@
// Shared types, constants and helpers for the elastic collision Euler step block.
// No dependencies.
package ece_pkg;

    localparam int MAX_BODIES_DEF = 64;
    localparam int DIV_W          = 52;  // holds any collision numerator, signed
    localparam int PROD_W         = 50;  // 18 x 32 signed product

    localparam logic REG_TIME_STEP    = 1'b0;
    localparam logic REG_OBJECT_COUNT = 1'b1;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [15:0] TIME_STEP_RST = 16'd1092;

    typedef struct packed {
        logic               cmd;
        logic        [5:0]  index;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] acc_x;
        logic signed [31:0] acc_y;
        logic        [15:0] mass;
        logic        [30:0] width;
        logic        [30:0] height;
    } ece_req_t;

    typedef struct packed {
        logic        [5:0]  out_index;
        logic signed [31:0] new_pos_x;
        logic signed [31:0] new_pos_y;
        logic signed [31:0] new_vel_x;
        logic signed [31:0] new_vel_y;
        logic        [5:0]  hit_count;
        logic               zero_mass_flag;
    } ece_rsp_t;

    typedef struct packed {
        logic signed [31:0] px;
        logic signed [31:0] py;
        logic signed [31:0] vx;
        logic signed [31:0] vy;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic        [15:0] m;
        logic        [30:0] w;
        logic        [30:0] h;
    } body_t;

    typedef struct packed {
        logic pos;
        logic vel;
        logic rest;   // acceleration, mass and size
    } wr_en_t;

    localparam logic signed [DIV_W-1:0] S32_MAX = DIV_W'(64'sd2147483647);
    localparam logic signed [DIV_W-1:0] S32_MIN = DIV_W'(-64'sd2147483648);

    function automatic logic signed [31:0] sat32(input logic signed [DIV_W-1:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7fffffff;
        else if (v < S32_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // add half an lsb, then floor by taking the high bits
    function automatic logic signed [33:0] round16(input logic signed [PROD_W-1:0] p);
        logic signed [PROD_W-1:0] t;
        t = p + PROD_W'(32768);
        return t[PROD_W-1:16];
    endfunction

endpackage

@@ rtl/core/ece_if.sv @@
// Channel interfaces: request, result and configuration write.
// Depends on ece_pkg.
interface ece_req_if import ece_pkg::*; ();
    logic     valid;
    logic     ready;
    ece_req_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ece_rsp_if import ece_pkg::*; ();
    logic     valid;
    logic     ready;
    ece_rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface ece_cfg_if ();
    logic        valid;
    logic        ready;
    logic        index;
    logic [15:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

@@ rtl/core/ece_div.sv @@
// Iterative restoring divider, one quotient bit per cycle, truncating toward zero.
// Depends on ece_pkg.
module ece_div import ece_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DIV_W-1:0] num,
    input  logic        [16:0]      den,
    output logic                    done,
    output logic signed [DIV_W-1:0] quot
);
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] mag_reg, mag_next;
    logic [17:0]      rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             neg_reg, neg_next;
    logic             done_reg, done_next;
    logic [17:0]      trial;

    always_comb
    begin
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        neg_next  = neg_reg;
        done_next = 1'b0;
        trial     = {rem_reg[16:0], mag_reg[DIV_W-1]};
        if (start)
        begin
            neg_next  = num[DIV_W-1];
            mag_next  = num[DIV_W-1] ? DIV_W'(-num) : DIV_W'(num);
            rem_next  = '0;
            cnt_next  = CNT_W'(DIV_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, den})
            begin
                rem_next = trial - {1'b0, den};
                mag_next = {mag_reg[DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                mag_next = {mag_reg[DIV_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign done = done_reg;
    assign quot = neg_reg ? -$signed(mag_reg) : $signed(mag_reg);

endmodule

@@ rtl/core/ece_store.sv @@
// Body table memories: one write address, one read port with registered data.
// Depends on ece_pkg.
module ece_store import ece_pkg::*;
#(
    parameter int MAX_BODIES = MAX_BODIES_DEF,
    parameter int AW         = $clog2(MAX_BODIES)
)
(
    input  logic          clk,
    input  wr_en_t        wr_en,
    input  logic [AW-1:0] wr_addr,
    input  body_t         wr_data,
    input  logic [AW-1:0] rd_addr,
    output body_t         rd_data
);
    logic [63:0] pos_mem  [MAX_BODIES];
    logic [63:0] vel_mem  [MAX_BODIES];
    logic [63:0] acc_mem  [MAX_BODIES];
    logic [15:0] mass_mem [MAX_BODIES];
    logic [61:0] size_mem [MAX_BODIES];

    always_ff @(posedge clk)
    begin
        if (wr_en.pos)
            pos_mem[wr_addr] <= {wr_data.py, wr_data.px};
        if (wr_en.vel)
            vel_mem[wr_addr] <= {wr_data.vy, wr_data.vx};
        if (wr_en.rest)
        begin
            acc_mem[wr_addr]  <= {wr_data.ay, wr_data.ax};
            mass_mem[wr_addr] <= wr_data.m;
            size_mem[wr_addr] <= {wr_data.h, wr_data.w};
        end
    end

    always_ff @(posedge clk)
    begin
        {rd_data.py, rd_data.px} <= pos_mem[rd_addr];
        {rd_data.vy, rd_data.vx} <= vel_mem[rd_addr];
        {rd_data.ay, rd_data.ax} <= acc_mem[rd_addr];
        rd_data.m                <= mass_mem[rd_addr];
        {rd_data.h, rd_data.w}   <= size_mem[rd_addr];
    end

endmodule

@@ rtl/core/elastic_collision_euler_step.sv @@
// Top level: body table, sequencer, shared multiplier and divider.
// Depends on ece_pkg, ece_if, ece_div, ece_store.
//
//  channel | dir | beat contents
//  req     | in  | cmd, index, body fields (load only)
//  rsp     | out | index, new position and velocity, hit count, zero mass flag
//  cfg     | in  | register index (time step, object count), 16-bit data
//
// A load writes its table entry as it is accepted. A tick reads its entry, then
// walks the table; each overlapping pair with nonzero mass sum runs four divisions
// of 52 quotient bits through the one divider before the Euler step. req is ready
// only while idle. Reset clears control state only; table contents stay undefined
// until loaded. A held result does not stop the next request being taken.
module elastic_collision_euler_step import ece_pkg::*;
#(
    parameter int MAX_BODIES = MAX_BODIES_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    ece_req_if.sink     req,
    ece_rsp_if.source   rsp,
    ece_cfg_if.sink     cfg
);
    localparam int AW = $clog2(MAX_BODIES);
    localparam int CW = $clog2(MAX_BODIES + 1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_RD_SELF = 5'd1;
    localparam logic [4:0] S_LD_SELF = 5'd2;
    localparam logic [4:0] S_RD_J    = 5'd3;
    localparam logic [4:0] S_CHK     = 5'd4;
    localparam logic [4:0] S_M1      = 5'd5;
    localparam logic [4:0] S_M2      = 5'd6;
    localparam logic [4:0] S_DS      = 5'd7;
    localparam logic [4:0] S_DW      = 5'd8;
    localparam logic [4:0] S_WB      = 5'd9;
    localparam logic [4:0] S_E0      = 5'd10;
    localparam logic [4:0] S_E1      = 5'd11;
    localparam logic [4:0] S_E2      = 5'd12;
    localparam logic [4:0] S_E3      = 5'd13;
    localparam logic [4:0] S_E4      = 5'd14;
    localparam logic [4:0] S_OUT     = 5'd15;

    logic [4:0]  state_reg, state_next;
    logic [15:0] dt_reg;
    logic [6:0]  ocount_reg;
    logic [5:0]  idx_reg, idx_next;
    logic [CW-1:0] j_reg, j_next, n_reg, n_next;
    logic [1:0]  k_reg, k_next;
    logic [5:0]  hits_reg, hits_next;
    logic        zflag_reg, zflag_next;
    body_t       self_reg, self_next;
    logic signed [31:0] ovx_reg, ovx_next, ovy_reg, ovy_next;
    logic [15:0] om_reg, om_next;
    logic signed [31:0] bres_reg [4];
    logic signed [31:0] bres_next [4];
    logic signed [PROD_W-1:0] prod_reg, acc_reg, acc_next;
    logic signed [17:0] mul_a;
    logic signed [31:0] mul_b;
    logic        rsp_valid_reg;
    ece_rsp_t    rsp_data_reg;

    wr_en_t        wr_en;
    logic [AW-1:0] wr_addr, rd_addr;
    body_t         wr_data, rd_data;
    logic          div_start, div_done;
    logic signed [DIV_W-1:0] div_num, div_quot;
    logic [16:0]   msum;
    logic          overlap;
    logic          idx_ok;
    logic [15:0]   ma, mb;
    logic signed [31:0] va, vb;
    logic signed [33:0] ax34, ay34, bx34, by34;

    ece_store #(.MAX_BODIES(MAX_BODIES), .AW(AW)) u_store (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    ece_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (msum),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = rsp_valid_reg;
    assign rsp.data  = rsp_data_reg;

    assign msum   = {1'b0, self_reg.m} + {1'b0, om_reg};
    assign idx_ok = (32'(idx_reg) < MAX_BODIES);

    // pair operands: first two bounces update the ticked body, last two the other
    assign mb = k_reg[1] ? self_reg.m : om_reg;
    assign ma = k_reg[1] ? om_reg : self_reg.m;
    always_comb
    begin
        case (k_reg)
            2'd0:    begin va = self_reg.vx; vb = ovx_reg;     end
            2'd1:    begin va = self_reg.vy; vb = ovy_reg;     end
            2'd2:    begin va = ovx_reg;     vb = self_reg.vx; end
            default: begin va = ovy_reg;     vb = self_reg.vy; end
        endcase
    end

    assign ax34 = 34'(self_reg.px);
    assign ay34 = 34'(self_reg.py);
    assign bx34 = 34'(rd_data.px);
    assign by34 = 34'(rd_data.py);
    assign overlap = (ax34 < bx34 + $signed({3'b000, rd_data.w}))
                  && (ax34 + $signed({3'b000, self_reg.w}) > bx34)
                  && (ay34 < by34 + $signed({3'b000, rd_data.h}))
                  && (ay34 + $signed({3'b000, self_reg.h}) > by34);

    assign div_num = DIV_W'(acc_reg) + DIV_W'(prod_reg);

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        j_next     = j_reg;
        n_next     = n_reg;
        k_next     = k_reg;
        hits_next  = hits_reg;
        zflag_next = zflag_reg;
        self_next  = self_reg;
        ovx_next   = ovx_reg;
        ovy_next   = ovy_reg;
        om_next    = om_reg;
        acc_next   = acc_reg;
        for (int i = 0; i < 4; i++)
            bres_next[i] = bres_reg[i];
        wr_en      = '0;
        wr_addr    = AW'(j_reg);
        wr_data    = self_reg;
        rd_addr    = AW'(j_reg);
        div_start  = 1'b0;
        mul_a      = $signed({2'b00, dt_reg});
        mul_b      = self_reg.ax;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    idx_next   = req.data.index;
                    hits_next  = '0;
                    zflag_next = 1'b0;
                    j_next     = '0;
                    n_next     = (32'(ocount_reg) > MAX_BODIES) ? CW'(MAX_BODIES)
                                                               : CW'(ocount_reg);
                    self_next  = '0;
                    if (32'(req.data.index) < MAX_BODIES)
                    begin
                        if (req.data.cmd == CMD_LOAD)
                        begin
                            self_next.px = req.data.pos_x;
                            self_next.py = req.data.pos_y;
                            self_next.vx = req.data.vel_x;
                            self_next.vy = req.data.vel_y;
                            self_next.ax = req.data.acc_x;
                            self_next.ay = req.data.acc_y;
                            self_next.m  = req.data.mass;
                            self_next.w  = req.data.width;
                            self_next.h  = req.data.height;
                            wr_en        = '{pos: 1'b1, vel: 1'b1, rest: 1'b1};
                            wr_addr      = AW'(req.data.index);
                            wr_data      = self_next;
                            state_next   = S_OUT;
                        end
                        else
                            state_next = S_RD_SELF;
                    end
                    else
                        state_next = S_OUT;
                end
            end
            S_RD_SELF:
            begin
                rd_addr    = AW'(idx_reg);
                state_next = S_LD_SELF;
            end
            S_LD_SELF:
            begin
                self_next  = rd_data;
                state_next = S_RD_J;
            end
            S_RD_J:
            begin
                if (j_reg >= n_reg)
                    state_next = S_E0;
                else if (32'(j_reg) == 32'(idx_reg))
                    j_next = j_reg + 1'b1;
                else
                    state_next = S_CHK;
            end
            S_CHK:
            begin
                ovx_next = rd_data.vx;
                ovy_next = rd_data.vy;
                om_next  = rd_data.m;
                j_next   = j_reg + 1'b1;
                state_next = S_RD_J;
                if (overlap)
                begin
                    if (hits_reg != 6'd63)
                        hits_next = hits_reg + 1'b1;
                    if (({1'b0, self_reg.m} + {1'b0, rd_data.m}) == 17'd0)
                        zflag_next = 1'b1;
                    else
                    begin
                        j_next     = j_reg;
                        k_next     = 2'd0;
                        state_next = S_M1;
                    end
                end
            end
            S_M1:
            begin
                mul_a      = $signed({1'b0, mb, 1'b0});
                mul_b      = vb;
                state_next = S_M2;
            end
            S_M2:
            begin
                acc_next   = prod_reg;
                mul_a      = $signed({2'b00, ma}) - $signed({2'b00, mb});
                mul_b      = va;
                state_next = S_DS;
            end
            S_DS:
            begin
                div_start  = 1'b1;
                state_next = S_DW;
            end
            S_DW:
            begin
                if (div_done)
                begin
                    bres_next[k_reg] = sat32(div_quot);
                    if (k_reg == 2'd3)
                        state_next = S_WB;
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = S_M1;
                    end
                end
            end
            S_WB:
            begin
                self_next.vx = bres_reg[0];
                self_next.vy = bres_reg[1];
                wr_data.vx   = bres_reg[2];
                wr_data.vy   = bres_reg[3];
                wr_en.vel    = 1'b1;
                j_next       = j_reg + 1'b1;
                state_next   = S_RD_J;
            end
            S_E0:
            begin
                mul_b      = self_reg.ax;
                state_next = S_E1;
            end
            S_E1:
            begin
                self_next.vx = sat32(DIV_W'(self_reg.vx) + DIV_W'(round16(prod_reg)));
                mul_b        = self_reg.ay;
                state_next   = S_E2;
            end
            S_E2:
            begin
                self_next.vy = sat32(DIV_W'(self_reg.vy) + DIV_W'(round16(prod_reg)));
                mul_b        = self_reg.vx;
                state_next   = S_E3;
            end
            S_E3:
            begin
                self_next.px = sat32(DIV_W'(self_reg.px) + DIV_W'(round16(prod_reg)));
                mul_b        = self_reg.vy;
                state_next   = S_E4;
            end
            S_E4:
            begin
                self_next.py = sat32(DIV_W'(self_reg.py) + DIV_W'(round16(prod_reg)));
                wr_data      = self_next;
                wr_addr      = AW'(idx_reg);
                wr_en.pos    = idx_ok;
                wr_en.vel    = idx_ok;
                state_next   = S_OUT;
            end
            S_OUT:
            begin
                if (!rsp_valid_reg || rsp.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            dt_reg        <= TIME_STEP_RST;
            ocount_reg    <= '0;
            rsp_valid_reg <= 1'b0;
            j_reg         <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            hits_reg      <= '0;
            zflag_reg     <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            j_reg     <= j_next;
            n_reg     <= n_next;
            k_reg     <= k_next;
            hits_reg  <= hits_next;
            zflag_reg <= zflag_next;
            idx_reg   <= idx_next;
            if (cfg.valid)
            begin
                case (cfg.index)
                    REG_TIME_STEP:    dt_reg     <= cfg.data;
                    REG_OBJECT_COUNT: ocount_reg <= cfg.data[6:0];
                    default:          ;
                endcase
            end
            if (state_reg == S_OUT && (!rsp_valid_reg || rsp.ready))
                rsp_valid_reg <= 1'b1;
            else if (rsp.ready)
                rsp_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        self_reg <= self_next;
        ovx_reg  <= ovx_next;
        ovy_reg  <= ovy_next;
        om_reg   <= om_next;
        acc_reg  <= acc_next;
        prod_reg <= mul_a * mul_b;
        for (int i = 0; i < 4; i++)
            bres_reg[i] <= bres_next[i];
        if (state_reg == S_OUT && (!rsp_valid_reg || rsp.ready))
        begin
            rsp_data_reg.out_index      <= idx_reg;
            rsp_data_reg.new_pos_x      <= self_reg.px;
            rsp_data_reg.new_pos_y      <= self_reg.py;
            rsp_data_reg.new_vel_x      <= self_reg.vx;
            rsp_data_reg.new_vel_y      <= self_reg.vy;
            rsp_data_reg.hit_count      <= hits_reg;
            rsp_data_reg.zero_mass_flag <= zflag_reg;
        end
    end

    a_div_only_waiting: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> state_reg == S_DW)
        else $error("divider finished outside its wait state");

    a_walk_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_RD_J |-> j_reg <= n_reg)
        else $error("walk index passed the walk length");

    a_wb_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WB |-> $past(state_reg) == S_DW && $past(k_reg) == 2'd3)
        else $error("velocity write-back without all four bounces");

endmodule

@@ sim/elastic_collision_euler_step_test.sv @@
// Self-checking test of elastic_collision_euler_step: loads, ticks, collisions,
// saturation and register settings, with random idling on the request and result channels.
// Depends on ece_pkg, ece_if and the RTL of the block.
`timescale 1ns / 100ps

module elastic_collision_euler_step_test;
    import ece_pkg::*;

    localparam int  NBODY       = 64;
    localparam int  STALL_LIMIT = 60000;
    localparam int  SETTLE      = 40;

    logic clk;
    logic rst_n;

    ece_req_if req ();
    ece_rsp_if rsp ();
    ece_cfg_if cfg ();

    elastic_collision_euler_step DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source),
        .cfg   (cfg.sink)
    );

    // shadow of the body table and registers
    body_t       shadow_body [NBODY];
    logic [15:0] shadow_dt;
    logic [6:0]  shadow_count;

    ece_rsp_t    pending_rsp [$];
    int          err_count;
    int          sent_items;
    int          got_rsp;
    int          tick_items;
    int          hit_rsp;
    int          zero_rsp;
    int          idle_cycles;
    bit          no_gaps;     // stretches with no idling on either side
    bit          rsp_accept;
    bit          req_accept;
    bit          cfg_accept;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647)
            return 32'sh7fffffff;
        if (v < -64'sd2147483648)
            return 32'sh80000000;
        return v[31:0];
    endfunction

    // add half an lsb, then floor
    function automatic longint half_up16(input longint p);
        return (p + 64'sd32768) >>> 16;
    endfunction

    function automatic logic signed [31:0] elastic_vel(input longint ma, input longint mb,
                                                       input longint va, input longint vb);
        longint num;
        num = 2 * mb * vb + (ma - mb) * va;
        return clamp32(num / (ma + mb));
    endfunction

    function automatic bit boxes_overlap(input body_t a, input body_t b);
        longint ax, ay, bx, by;
        ax = a.px;
        ay = a.py;
        bx = b.px;
        by = b.py;
        return ax < bx + longint'(b.w) && ax + longint'(a.w) > bx &&
               ay < by + longint'(b.h) && ay + longint'(a.h) > by;
    endfunction

    function automatic ece_rsp_t body_step(input ece_req_t r);
        ece_rsp_t o;
        int       walk;
        int       hits;
        bit       zflag;
        longint   m1, m2, v1x, v1y, v2x, v2y, dt;
        int       i;
        body_t    b;
        o = '0;
        o.out_index = r.index;
        hits = 0;
        zflag = 1'b0;
        i = r.index;
        dt = longint'(shadow_dt);
        if (r.cmd == CMD_LOAD)
        begin
            shadow_body[i] = '{r.pos_x, r.pos_y, r.vel_x, r.vel_y, r.acc_x, r.acc_y,
                               r.mass, r.width, r.height};
        end
        else
        begin
            walk = (shadow_count > NBODY) ? NBODY : int'(shadow_count);
            for (int j = 0; j < walk; j++)
            begin
                if (j == i || !boxes_overlap(shadow_body[i], shadow_body[j]))
                    continue;
                if (hits < 63)
                    hits++;
                m1 = shadow_body[i].m;
                m2 = shadow_body[j].m;
                if (m1 + m2 == 0)
                begin
                    zflag = 1'b1;
                    continue;
                end
                v1x = shadow_body[i].vx;
                v1y = shadow_body[i].vy;
                v2x = shadow_body[j].vx;
                v2y = shadow_body[j].vy;
                shadow_body[i].vx = elastic_vel(m1, m2, v1x, v2x);
                shadow_body[i].vy = elastic_vel(m1, m2, v1y, v2y);
                shadow_body[j].vx = elastic_vel(m2, m1, v2x, v1x);
                shadow_body[j].vy = elastic_vel(m2, m1, v2y, v1y);
            end
            b = shadow_body[i];
            b.vx = clamp32(longint'(b.vx) + half_up16(longint'(b.ax) * dt));
            b.vy = clamp32(longint'(b.vy) + half_up16(longint'(b.ay) * dt));
            b.px = clamp32(longint'(b.px) + half_up16(longint'(b.vx) * dt));
            b.py = clamp32(longint'(b.py) + half_up16(longint'(b.vy) * dt));
            shadow_body[i] = b;
        end
        o.new_pos_x = shadow_body[i].px;
        o.new_pos_y = shadow_body[i].py;
        o.new_vel_x = shadow_body[i].vx;
        o.new_vel_y = shadow_body[i].vy;
        o.hit_count = hits[5:0];
        o.zero_mass_flag = zflag;
        return o;
    endfunction

    // valid stays high across back-to-back beats; lowered only ahead of a gap
    task automatic send_item(input ece_req_t r);
        int g;
        g = gap_len();
        if (g > 0)
        begin
            req.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        req.valid <= 1'b1;
        req.data  <= r;
        do @(posedge clk); while (!req_accept);
        pending_rsp.push_back(body_step(r));
        sent_items++;
        if (r.cmd == CMD_TICK)
            tick_items++;
    endtask

    task automatic wait_idle();
        req.valid <= 1'b0;
        while (pending_rsp.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg_accept);
        cfg.valid <= 1'b0;
        if (idx == REG_TIME_STEP)
            shadow_dt = value;
        else
            shadow_count = value[6:0];
        @(posedge clk);
    endtask

    function automatic ece_req_t load_beat(input int idx, input int px, input int py,
                                           input int vx, input int vy, input int ax,
                                           input int ay, input logic [15:0] m,
                                           input logic [30:0] w, input logic [30:0] h);
        ece_req_t r;
        r = '{CMD_LOAD, idx[5:0], px, py, vx, vy, ax, ay, m, w, h};
        return r;
    endfunction

    function automatic ece_req_t tick_beat(input int idx);
        ece_req_t r;
        r = ece_req_t'($urandom) ^ {$urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom};
        r.cmd = CMD_TICK;
        r.index = idx[5:0];
        return r;
    endfunction

    // small values mostly, full range now and then
    function automatic int pick_signed(input int span);
        if ($urandom_range(0, 9) == 0)
            return $urandom;
        return $urandom_range(0, 2 * span) - span;
    endfunction

    function automatic ece_req_t random_load(input int idx);
        logic [15:0] m;
        int          r;
        r = $urandom_range(0, 19);
        m = (r == 0) ? 16'd0 : (r == 1) ? 16'hffff : 16'($urandom_range(1, 65535));
        if ($urandom_range(0, 19) == 0)
            return load_beat(idx, $urandom, $urandom, $urandom, $urandom, $urandom,
                             $urandom, m, 31'($urandom), 31'($urandom));
        return load_beat(idx, $urandom_range(0, 32'h0010_0000),
                         $urandom_range(0, 32'h0010_0000),
                         pick_signed(32'h0004_0000), pick_signed(32'h0004_0000),
                         pick_signed(32'h0002_0000), pick_signed(32'h0002_0000), m,
                         31'($urandom_range(0, 32'h0004_0000)),
                         31'($urandom_range(0, 32'h0004_0000)));
    endfunction

    // every entry is loaded before anything walks the table
    task automatic test_table_fill();
        for (int i = 0; i < NBODY; i++)
            send_item(random_load(i));
    endtask

    task automatic test_directed();
        wait_idle();
        write_reg(REG_OBJECT_COUNT, 16'd0);
        send_item(tick_beat(5));            // empty walk
        wait_idle();
        write_reg(REG_OBJECT_COUNT, 16'd64);
        write_reg(REG_TIME_STEP, 16'hffff);
        // widest boxes at the corners of the space
        send_item(load_beat(0, 32'h80000000, 32'h80000000, 32'h7fffffff, 32'h80000000,
                            32'h7fffffff, 32'h80000000, 16'hffff, 31'h7fffffff,
                            31'h7fffffff));
        send_item(load_beat(1, 32'h7fffffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff,
                            32'h80000000, 32'h7fffffff, 16'd1, 31'h7fffffff,
                            31'h7fffffff));
        send_item(tick_beat(0));
        send_item(tick_beat(1));
        // pair of massless bodies: flagged and left alone
        send_item(load_beat(2, 32'h4000_0000, 32'h4000_0000, 32'h0001_0000, 0, 0, 0,
                            16'd0, 31'h0002_0000, 31'h0002_0000));
        send_item(load_beat(3, 32'h4001_0000, 32'h4001_0000, -32'sh0001_0000, 0, 0, 0,
                            16'd0, 31'h0002_0000, 31'h0002_0000));
        send_item(tick_beat(2));
        // boxes that touch at an edge do not overlap
        send_item(load_beat(4, 32'h4002_0000, 32'h4000_0000, 0, 0, 0, 0, 16'd5,
                            31'h0001_0000, 31'h0001_0000));
        send_item(tick_beat(4));
        send_item(tick_beat(3));
        // zero sized box
        send_item(load_beat(6, 32'h4000_8000, 32'h4000_8000, 0, 0, 0, 0, 16'd7, 0, 0));
        send_item(tick_beat(6));
        wait_idle();
        // ticked entry outside the walk still meets the walked ones
        write_reg(REG_OBJECT_COUNT, 16'd4);
        write_reg(REG_TIME_STEP, 16'd0);
        send_item(load_beat(40, 32'h4000_0000, 32'h4000_0000, 32'h0003_0000, 0, 0, 0,
                            16'd3, 31'h0001_0000, 31'h0001_0000));
        send_item(tick_beat(40));
        wait_idle();
        // count beyond the table walks the whole table
        write_reg(REG_OBJECT_COUNT, 16'd100);
        write_reg(REG_TIME_STEP, 16'd1);
        send_item(tick_beat(40));
        send_item(tick_beat(63));
    endtask

    task automatic test_random_phases();
        int n;
        int r;
        while (sent_items < 215)
        begin
            wait_idle();
            no_gaps = ($urandom_range(0, 3) == 0);
            r = $urandom_range(0, 9);
            write_reg(REG_TIME_STEP, (r == 0) ? 16'd0 : (r == 1) ? 16'hffff :
                      16'($urandom));
            r = $urandom_range(0, 9);
            write_reg(REG_OBJECT_COUNT, (r == 0) ? 16'd64 : (r == 1) ? 16'd127 :
                      (r == 2) ? 16'd0 : 16'($urandom_range(2, 16)));
            n = $urandom_range(10, 25);
            repeat (n)
            begin
                if ($urandom_range(0, 99) < 35)
                    send_item(random_load($urandom_range(0, 63)));
                else if ($urandom_range(0, 1) == 0)
                    send_item(tick_beat($urandom_range(0, 15)));
                else
                    send_item(tick_beat($urandom_range(0, 63)));
            end
        end
        wait_idle();
        no_gaps = 1'b0;
    endtask

    // handshake flags sampled at the falling edge, away from the driving edge
    always @(negedge clk)
    begin
        req_accept = req.valid && req.ready;
        cfg_accept = cfg.valid && cfg.ready;
        rsp_accept = rsp.valid && rsp.ready;
        if (rsp_accept)
        begin
            if (pending_rsp.size() == 0)
            begin
                $error("result beat with nothing expected, index %0d",
                       rsp.data.out_index);
                err_count++;
            end
            else
            begin
                ece_rsp_t e;
                ece_rsp_t a;
                e = pending_rsp.pop_front();
                a = rsp.data;
                got_rsp++;
                if (e.hit_count != 0)
                    hit_rsp++;
                if (e.zero_mass_flag)
                    zero_rsp++;
                if (a.out_index !== e.out_index)
                begin
                    $error("out_index: expected %0d, got %0d", e.out_index, a.out_index);
                    err_count++;
                end
                if (a.new_pos_x !== e.new_pos_x)
                begin
                    $error("new_pos_x: expected %0d, got %0d", e.new_pos_x, a.new_pos_x);
                    err_count++;
                end
                if (a.new_pos_y !== e.new_pos_y)
                begin
                    $error("new_pos_y: expected %0d, got %0d", e.new_pos_y, a.new_pos_y);
                    err_count++;
                end
                if (a.new_vel_x !== e.new_vel_x)
                begin
                    $error("new_vel_x: expected %0d, got %0d", e.new_vel_x, a.new_vel_x);
                    err_count++;
                end
                if (a.new_vel_y !== e.new_vel_y)
                begin
                    $error("new_vel_y: expected %0d, got %0d", e.new_vel_y, a.new_vel_y);
                    err_count++;
                end
                if (a.hit_count !== e.hit_count)
                begin
                    $error("hit_count: expected %0d, got %0d", e.hit_count, a.hit_count);
                    err_count++;
                end
                if (a.zero_mass_flag !== e.zero_mass_flag)
                begin
                    $error("zero_mass_flag: expected %0d, got %0d", e.zero_mass_flag,
                           a.zero_mass_flag);
                    err_count++;
                end
            end
        end
    end

    // result side back-pressure
    int rsp_hold;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp.ready <= 1'b0;
            rsp_hold  <= 0;
        end
        else if (rsp_hold > 0)
        begin
            rsp.ready <= 1'b0;
            rsp_hold  <= rsp_hold - 1;
        end
        else
        begin
            rsp.ready <= 1'b1;
            if (rsp.valid && rsp.ready)
                rsp_hold <= gap_len();
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || req_accept || cfg_accept || rsp_accept)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("no beat for %0d cycles, %0d results outstanding", STALL_LIMIT,
                     pending_rsp.size());
            $display("elastic_collision_euler_step: mismatch");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        req.valid    = 1'b0;
        req.data     = '0;
        cfg.valid    = 1'b0;
        cfg.index    = REG_TIME_STEP;
        cfg.data     = '0;
        shadow_dt    = TIME_STEP_RST;
        shadow_count = '0;
        sent_items   = 0;
        tick_items   = 0;
        no_gaps      = 1'b0;
        for (int i = 0; i < NBODY; i++)
            shadow_body[i] = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_table_fill();
        test_directed();
        test_random_phases();

        $display("%0d beats in (%0d ticks), %0d results checked", sent_items, tick_items,
                 got_rsp);
        $display("%0d results with collisions, %0d with a massless pair", hit_rsp,
                 zero_rsp);
        if (err_count == 0 && pending_rsp.size() == 0)
            $display("elastic_collision_euler_step: match");
        else
            $display("elastic_collision_euler_step: mismatch");
        $finish;
    end

endmodule

@@ elastic_collision_euler_step.f @@
rtl/core/ece_pkg.sv
rtl/core/ece_if.sv
rtl/core/ece_div.sv
rtl/core/ece_store.sv
rtl/core/elastic_collision_euler_step.sv
sim/elastic_collision_euler_step_test.sv
